// ===== rtl/stpm_pkg.sv =====
// ----------------------------------------------------------------------------
// stpm_pkg: shared types and constants for the stereo tremolo / peak meter
// Operation codes of the shared multiplier, sequencer states, register map.
// ----------------------------------------------------------------------------
package stpm_pkg;

  // Unity gain in Q16
  localparam int unsigned UNITY = 65536;

  // Width of the multiplier's second operand (20-bit unsigned gain + sign)
  localparam int unsigned MUL_B_BITS = 21;

  // Display clamp, signed Q1.15
  localparam int DISP_MAX = 32767;
  localparam int DISP_MIN = -32768;

  // pi/2 in Q30 and the Taylor denominators (2n)(2n+1) for the sine table
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

  typedef enum logic [1:0] {
    MUL_SCALE,  // sample * gain, round >> 16, clamp to sample range
    MUL_GAIN,   // depth * (1 + wave) + offset, round >> 17
    MUL_OUT,    // scaled sample * channel gain, round >> 16, clamp
    MUL_DISP    // wave * depth, round >> 17, clamp to Q1.15
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SCALE_WB,
    ST_TAB_B,
    ST_GAIN_L,
    ST_GAIN_L_WB,
    ST_GAIN_R,
    ST_GAIN_R_WB,
    ST_OUT_L,
    ST_OUT_L_WB,
    ST_OUT_R,
    ST_OUT_R_WB,
    ST_DISP,
    ST_DISP_WB,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    REG_GAIN_LINEAR,
    REG_PHASE_STEP,
    REG_LFO_DEPTH
  } reg_idx_t;

endpackage

// ===== rtl/stereo_tremolo_with_peak_meter.sv =====
// ----------------------------------------------------------------------------
// stereo_tremolo_with_peak_meter: mono in, tremolo/autopan stereo out, meters
// Result valid follows the sequencer walk started by an input transaction.
// A new sample is taken only once the last has been loaded into the result
// register; the shared multiplier issues six products and two sine ROM reads per sample.
// Reset (synchronous, rst_n low): gain 1.0, step 0, depth 0, phase and peaks 0.
// ----------------------------------------------------------------------------
module stereo_tremolo_with_peak_meter import stpm_pkg::*; #(
  parameter int SAMPLE_BITS     = 24,
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          in_last_of_block,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          out_meters_valid,
  output logic        [SAMPLE_BITS-2:0] out_peak_input,
  output logic        [SAMPLE_BITS-2:0] out_peak_left,
  output logic        [SAMPLE_BITS-2:0] out_peak_right,
  output logic signed [15:0]            out_lfo_display,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic        [3:0]             paddr,
  input  logic        [31:0]            pwdata,
  output logic        [31:0]            prdata,
  output logic                          pready
);

  localparam int AW     = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int PW     = AW + MUL_B_BITS;
  localparam int TBL_N  = 1 << SINE_TABLE_BITS;
  localparam int STEP_W = (PHASE_BITS < 31) ? PHASE_BITS : 31;

  localparam logic [SINE_TABLE_BITS:0]   TBL_TOP = {1'b1, {SINE_TABLE_BITS{1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [16:0] UNITY_Q16 = 17'(UNITY);

  // --------------------------------------------------------------------------
  // Quarter-wave sine ROM, Q16 over [0, pi/2], built at elaboration from a
  // Taylor series through x^15 with Q30 truncating term steps.
  // --------------------------------------------------------------------------
  typedef logic [16:0] rom_t [0:TBL_N];

  function automatic rom_t build_sine_rom();
    rom_t                tbl;
    longint unsigned     x;
    longint unsigned     t;
    longint              sum;
    longint              q;
    for (int k = 0; k <= TBL_N; k++) begin
      x   = (longint'(k) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      t   = x;
      sum = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / TAYLOR_DIV[n-1];
        if ((n & 1) == 1) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      q = (sum + 8192) >>> 14;
      if (q < 0) begin
        q = 0;
      end else if (q > longint'(UNITY)) begin
        q = longint'(UNITY);
      end
      tbl[k] = 17'(q);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [19:0]             gain_r;
  logic [30:0]             step_r;
  logic [16:0]             depth_r;

  logic [PHASE_BITS-1:0]   phase_r;
  logic [SAMPLE_BITS-2:0]  pk_in_r, pk_l_r, pk_r_r;

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                    last_r;
  logic signed [SAMPLE_BITS-1:0] xs_r, ol_r, or_r;
  logic [16:0]             tab_a_r, tab_b_r;
  logic [16:0]             gl_r, gr_r;
  logic signed [15:0]      disp_r;
  logic [16:0]             rom_q_r;

  logic                    out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;
  logic                    out_mv_r;
  logic [SAMPLE_BITS-2:0]  out_pk_in_r, out_pk_l_r, out_pk_r_r;
  logic signed [15:0]      out_disp_r;

  // --------------------------------------------------------------------------
  // Configuration port: writes land on the access phase, reads are direct.
  // --------------------------------------------------------------------------
  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_LINEAR: prdata = {12'd0, gain_r};
      REG_PHASE_STEP:  prdata = {1'b0, step_r};
      REG_LFO_DEPTH:   prdata = {15'd0, depth_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 20'(UNITY);
      step_r  <= '0;
      depth_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_LINEAR: gain_r  <= pwdata[19:0];
        REG_PHASE_STEP:  step_r  <= pwdata[30:0];
        REG_LFO_DEPTH:   depth_r <= pwdata[16:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // LFO lookup: quadrant from the top two phase bits, table index below.
  // The ROM is read twice per sample: T[idx], then T[N - idx].
  // --------------------------------------------------------------------------
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic signed [17:0]         tab_a_s, tab_b_s;
  logic signed [17:0]         wave_s, wave_c;
  logic [16:0]                depth_eff;
  logic [16:0]                depth_comp;

  assign quad = phase_r[PHASE_BITS-1 -: 2];
  assign idx  = phase_r[PHASE_BITS-3 -: SINE_TABLE_BITS];

  // first read in ST_SCALE, second read while the first is written back
  assign rom_addr = (state_r == ST_SCALE) ? {1'b0, idx} : (TBL_TOP - {1'b0, idx});

  always_ff @(posedge clk) begin
    rom_q_r <= SINE_ROM[rom_addr];
  end

  assign tab_a_s = signed'({1'b0, tab_a_r});
  assign tab_b_s = signed'({1'b0, tab_b_r});

  // sine on the left, cosine on the right, unfolded from the quarter wave
  always_comb begin
    unique case (quad)
      2'd0: begin
        wave_s = tab_a_s;
        wave_c = tab_b_s;
      end
      2'd1: begin
        wave_s = tab_b_s;
        wave_c = -tab_a_s;
      end
      2'd2: begin
        wave_s = -tab_a_s;
        wave_c = -tab_b_s;
      end
      default: begin
        wave_s = -tab_b_s;
        wave_c = tab_a_s;
      end
    endcase
  end

  // depth above full scale acts as full depth
  assign depth_eff  = (depth_r > UNITY_Q16) ? UNITY_Q16 : depth_r;
  assign depth_comp = UNITY_Q16 - depth_eff;

  // --------------------------------------------------------------------------
  // Shared multiplier: operands are chosen by the sequencer state; the rounded
  // result, clamped but for the gain op, comes back in the following _WB state.
  // --------------------------------------------------------------------------
  mul_op_t                      mul_op;
  logic signed [AW-1:0]         mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [PW-1:0]         mul_add;
  logic signed [AW-1:0]         mul_res;
  logic signed [18:0]           one_plus_w;

  always_comb begin
    mul_op     = MUL_SCALE;
    mul_a      = AW'(sample_r);
    mul_b      = signed'({1'b0, gain_r});
    mul_add    = '0;
    one_plus_w = 19'(signed'({2'b00, UNITY_Q16}));
    unique case (state_r)
      ST_GAIN_L, ST_GAIN_R: begin
        // d * (1 + w) + (1 - d) * 2, then the unit rounds off 17 bits
        if (state_r == ST_GAIN_L) begin
          one_plus_w = 19'(signed'({2'b00, UNITY_Q16})) + 19'(wave_s);
        end else begin
          one_plus_w = 19'(signed'({2'b00, UNITY_Q16})) + 19'(wave_c);
        end
        mul_op  = MUL_GAIN;
        mul_a   = AW'(signed'({1'b0, depth_eff}));
        mul_b   = MUL_B_BITS'(one_plus_w);
        mul_add = PW'(signed'({1'b0, depth_comp, 17'd0}));
      end
      ST_OUT_L: begin
        mul_op = MUL_OUT;
        mul_a  = AW'(xs_r);
        mul_b  = MUL_B_BITS'(signed'({1'b0, gl_r}));
      end
      ST_OUT_R: begin
        mul_op = MUL_OUT;
        mul_a  = AW'(xs_r);
        mul_b  = MUL_B_BITS'(signed'({1'b0, gr_r}));
      end
      ST_DISP: begin
        mul_op = MUL_DISP;
        mul_a  = AW'(signed'({1'b0, depth_eff}));
        mul_b  = MUL_B_BITS'(wave_s);
      end
      default: ;  // hold the scale operands
    endcase
  end

  stpm_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk    (clk),
    .op     (mul_op),
    .a      (mul_a),
    .b      (mul_b),
    .addend (mul_add),
    .res    (mul_res)
  );

  // --------------------------------------------------------------------------
  // Absolute value of a sample-width result; the most negative value
  // saturates to full scale. Shared by the three peak holds.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] res_smp;
  logic signed [SAMPLE_BITS-1:0] res_abs_full;
  logic [SAMPLE_BITS-2:0]        res_abs;

  assign res_smp = SAMPLE_BITS'(mul_res);

  always_comb begin
    if (res_smp == SMIN) begin
      res_abs_full = SMAX;
    end else if (res_smp[SAMPLE_BITS-1]) begin
      res_abs_full = -res_smp;
    end else begin
      res_abs_full = res_smp;
    end
    res_abs = res_abs_full[SAMPLE_BITS-2:0];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic in_acc;
  logic out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  // the result register frees up when it is empty or being taken this cycle
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_acc) state_nxt = ST_SCALE;
      ST_SCALE:     state_nxt = ST_SCALE_WB;
      ST_SCALE_WB:  state_nxt = ST_TAB_B;
      ST_TAB_B:     state_nxt = ST_GAIN_L;
      ST_GAIN_L:    state_nxt = ST_GAIN_L_WB;
      ST_GAIN_L_WB: state_nxt = ST_GAIN_R;
      ST_GAIN_R:    state_nxt = ST_GAIN_R_WB;
      ST_GAIN_R_WB: state_nxt = ST_OUT_L;
      ST_OUT_L:     state_nxt = ST_OUT_L_WB;
      ST_OUT_L_WB:  state_nxt = ST_OUT_R;
      ST_OUT_R:     state_nxt = ST_OUT_R_WB;
      ST_OUT_R_WB:  state_nxt = ST_DISP;
      ST_DISP:      state_nxt = ST_DISP_WB;
      ST_DISP_WB:   state_nxt = ST_DONE;
      ST_DONE:      if (out_load) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state: phase accumulator and block peak holds
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      pk_in_r <= '0;
      pk_l_r  <= '0;
      pk_r_r  <= '0;
    end else begin
      // advance the phase before it is used for this sample; wraps freely
      if (in_acc) begin
        phase_r <= phase_r + PHASE_BITS'(step_r[STEP_W-1:0]);
      end
      if (state_r == ST_SCALE_WB && res_abs > pk_in_r) begin
        pk_in_r <= res_abs;
      end
      if (state_r == ST_OUT_L_WB && res_abs > pk_l_r) begin
        pk_l_r <= res_abs;
      end
      if (state_r == ST_OUT_R_WB && res_abs > pk_r_r) begin
        pk_r_r <= res_abs;
      end
      // report closes the block: clear the holds
      if (out_load && last_r) begin
        pk_in_r <= '0;
        pk_l_r  <= '0;
        pk_r_r  <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Working registers: capture the transaction and write back each product
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample_in;
      last_r   <= in_last_of_block;
    end
    unique case (state_r)
      ST_SCALE_WB: begin
        xs_r    <= res_smp;
        tab_a_r <= rom_q_r;
      end
      ST_TAB_B:     tab_b_r <= rom_q_r;
      ST_GAIN_L_WB: gl_r    <= 17'(mul_res);
      ST_GAIN_R_WB: gr_r    <= 17'(mul_res);
      ST_OUT_L_WB:  ol_r    <= res_smp;
      ST_OUT_R_WB:  or_r    <= res_smp;
      ST_DISP_WB:   disp_r  <= 16'(mul_res);
      default: ;  // hold
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register: holds a finished transaction until the sink takes it.
  // Meter fields read zero unless the transaction closes a block.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r  <= ol_r;
      out_right_r <= or_r;
      out_mv_r    <= last_r;
      out_pk_in_r <= last_r ? pk_in_r : '0;
      out_pk_l_r  <= last_r ? pk_l_r  : '0;
      out_pk_r_r  <= last_r ? pk_r_r  : '0;
      out_disp_r  <= last_r ? disp_r  : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left         = out_left_r;
  assign out_right        = out_right_r;
  assign out_meters_valid = out_mv_r;
  assign out_peak_input   = out_pk_in_r;
  assign out_peak_left    = out_pk_l_r;
  assign out_peak_right   = out_pk_r_r;
  assign out_lfo_display  = out_disp_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // meter fields stay quiet on transactions that do not close a block
  a_meters_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_meters_valid) |->
      (out_peak_input == '0 && out_peak_left == '0 &&
       out_peak_right == '0 && out_lfo_display == '0))
    else $error("meter fields nonzero without meters_valid");

  // a new result only appears after the sequencer has finished a sample
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_DONE)
    else $error("result valid raised outside the done step");

  // channel gains never exceed unity
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_L) |-> (gl_r <= UNITY_Q16 && gr_r <= UNITY_Q16))
    else $error("channel gain above unity");
`endif

endmodule

// ===== rtl/stpm_mul.sv =====
// ----------------------------------------------------------------------------
// stpm_mul: shared multiply, round and clamp unit
// Registers the product, then adds offset and rounding, shifts, clamps non-gain ops.
// ----------------------------------------------------------------------------
module stpm_mul import stpm_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                   clk,
  input  mul_op_t                                op,
  input  logic signed [((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18)-1:0] a,
  input  logic signed [MUL_B_BITS-1:0]           b,
  input  logic signed [((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18)+MUL_B_BITS-1:0] addend,
  output logic signed [((SAMPLE_BITS > 18) ? SAMPLE_BITS : 18)-1:0] res
);

  localparam int AW = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int PW = AW + MUL_B_BITS;

  localparam logic signed [PW:0] SAT_HI = (PW+1)'((longint'(1) <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [PW:0] SAT_LO = -SAT_HI - 1;
  localparam logic signed [PW:0] D_HI   = (PW+1)'(DISP_MAX);
  localparam logic signed [PW:0] D_LO   = (PW+1)'(DISP_MIN);
  localparam logic signed [PW:0] RND16  = (PW+1)'(32768);
  localparam logic signed [PW:0] RND17  = (PW+1)'(65536);

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] add_r;
  mul_op_t              op_r;

  logic signed [PW:0]   sum;
  logic signed [PW:0]   sh;
  logic signed [PW:0]   clamped;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    add_r  <= addend;
    op_r   <= op;
  end

  always_comb begin
    sum = (PW+1)'(prod_r) + (PW+1)'(add_r);
    unique case (op_r)
      MUL_SCALE, MUL_OUT: begin
        sh = (sum + RND16) >>> 16;
        if (sh > SAT_HI) begin
          clamped = SAT_HI;
        end else if (sh < SAT_LO) begin
          clamped = SAT_LO;
        end else begin
          clamped = sh;
        end
      end
      MUL_GAIN: begin
        sh      = (sum + RND17) >>> 17;
        clamped = sh;
      end
      MUL_DISP: begin
        sh = (sum + RND17) >>> 17;
        if (sh > D_HI) begin
          clamped = D_HI;
        end else if (sh < D_LO) begin
          clamped = D_LO;
        end else begin
          clamped = sh;
        end
      end
      default: begin
        sh      = sum;
        clamped = sum;
      end
    endcase
    res = AW'(clamped);
  end

endmodule

// ===== test/tremolo_meter_checker.sv =====
// ----------------------------------------------------------------------------
// tremolo_meter_checker: scoreboard for the stereo tremolo / peak meter
// Tracks register writes on the APB port, predicts each stereo frame from
// every accepted input transaction and compares the result channel against
// it, field by field. Register reads are checked against the tracked copy.
// ----------------------------------------------------------------------------
module tremolo_meter_checker import stpm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [23:0] in_sample_in,
  input  logic               in_last_of_block,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [23:0] out_left,
  input  logic signed [23:0] out_right,
  input  logic               out_meters_valid,
  input  logic        [22:0] out_peak_input,
  input  logic        [22:0] out_peak_left,
  input  logic        [22:0] out_peak_right,
  input  logic signed [15:0] out_lfo_display,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  input  logic        [31:0] prdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     TABLE_W       = 10;
  localparam int     TABLE_LEN     = 1 << TABLE_W;
  localparam longint ONE_Q16       = 65536;
  localparam longint SAMPLE_TOP    = (longint'(1) << 23) - 1;
  localparam longint SAMPLE_BOTTOM = -(longint'(1) << 23);
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  typedef struct {
    longint left;
    longint right;
    bit     meters;
    longint peak_in;
    longint peak_l;
    longint peak_r;
    longint disp;
  } stereo_frame_t;

  longint        quarter_sine [0:TABLE_LEN];
  stereo_frame_t expected_frames [$];

  logic [19:0] gain_q16;
  logic [30:0] phase_inc;
  logic [16:0] depth_q16;
  logic [31:0] phase_acc;
  longint      in_peak, left_peak, right_peak;

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint abs_clamped(longint v);
    return clamp((v < 0) ? -v : v, 0, SAMPLE_TOP);
  endfunction

  function automatic longint channel_gain(longint wave, longint d);
    return round_shift(d * (ONE_Q16 + wave) + ((ONE_Q16 - d) << 17), 17);
  endfunction

  // Taylor series through x^15 in Q30, same truncation at every term
  function automatic longint sine_entry(int k);
    longint unsigned x, t;
    longint          acc;
    x   = (longint'(k) * QUARTER_TURN_Q30) >> TABLE_W;
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(t);
      else            acc = acc + longint'(t);
    end
    return clamp(round_shift(acc, 14), 0, ONE_Q16);
  endfunction

  initial begin
    for (int k = 0; k <= TABLE_LEN; k++) quarter_sine[k] = sine_entry(k);
  end

  // Advance the LFO and the peak holds by one sample
  function automatic stereo_frame_t next_frame(logic signed [23:0] smp, logic last_flag);
    stereo_frame_t f;
    longint        xs, sw, cw, d, ol, orr;
    int            idx;
    xs = clamp(round_shift(longint'(smp) * longint'(gain_q16), 16), SAMPLE_BOTTOM, SAMPLE_TOP);
    phase_acc = phase_acc + {1'b0, phase_inc};
    idx = int'(phase_acc[29:20]);
    case (phase_acc[31:30])
      2'd0: begin
        sw = quarter_sine[idx];
        cw = quarter_sine[TABLE_LEN - idx];
      end
      2'd1: begin
        sw = quarter_sine[TABLE_LEN - idx];
        cw = -quarter_sine[idx];
      end
      2'd2: begin
        sw = -quarter_sine[idx];
        cw = -quarter_sine[TABLE_LEN - idx];
      end
      default: begin
        sw = -quarter_sine[TABLE_LEN - idx];
        cw = quarter_sine[idx];
      end
    endcase
    d   = (longint'(depth_q16) > ONE_Q16) ? ONE_Q16 : longint'(depth_q16);
    ol  = clamp(round_shift(xs * channel_gain(sw, d), 16), SAMPLE_BOTTOM, SAMPLE_TOP);
    orr = clamp(round_shift(xs * channel_gain(cw, d), 16), SAMPLE_BOTTOM, SAMPLE_TOP);
    if (abs_clamped(xs) > in_peak)     in_peak    = abs_clamped(xs);
    if (abs_clamped(ol) > left_peak)   left_peak  = abs_clamped(ol);
    if (abs_clamped(orr) > right_peak) right_peak = abs_clamped(orr);
    f.left   = ol;
    f.right  = orr;
    f.meters = last_flag;
    if (last_flag) begin
      f.peak_in  = in_peak;
      f.peak_l   = left_peak;
      f.peak_r   = right_peak;
      f.disp     = clamp(round_shift(sw * d, 17), -32768, 32767);
      in_peak    = 0;
      left_peak  = 0;
      right_peak = 0;
    end else begin
      f.peak_in = 0;
      f.peak_l  = 0;
      f.peak_r  = 0;
      f.disp    = 0;
    end
    return f;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: tremolo_meter_checker: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, $signed(got), $signed(want)));
  endtask

  always @(posedge clk) begin
    stereo_frame_t want;
    logic [31:0]   reg_view;
    if (!rst_n) begin
      gain_q16   = 20'(ONE_Q16);
      phase_inc  = '0;
      depth_q16  = '0;
      phase_acc  = '0;
      in_peak    = 0;
      left_peak  = 0;
      right_peak = 0;
      mismatches = 0;
      expected_frames.delete();
    end else begin
      if (psel && penable && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_GAIN_LINEAR: reg_view = {12'd0, gain_q16};
          REG_PHASE_STEP:  reg_view = {1'b0, phase_inc};
          REG_LFO_DEPTH:   reg_view = {15'd0, depth_q16};
          default:         reg_view = 'x;
        endcase
        if (pwrite) begin
          case (reg_idx_t'(paddr[3:2]))
            REG_GAIN_LINEAR: gain_q16  = pwdata[19:0];
            REG_PHASE_STEP:  phase_inc = pwdata[30:0];
            REG_LFO_DEPTH:   depth_q16 = pwdata[16:0];
            default: ;
          endcase
        end else if (!$isunknown(reg_view) && prdata !== reg_view) begin
          report_mismatch($sformatf("read of register at 0x%0h got 0x%0h, expected 0x%0h",
                                    paddr, prdata, reg_view));
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          report_mismatch("result transaction with no frame expected");
        end else begin
          want = expected_frames.pop_front();
          check_field("out_left",         out_left,         want.left);
          check_field("out_right",        out_right,        want.right);
          check_field("out_meters_valid", out_meters_valid, want.meters);
          check_field("out_peak_input",   out_peak_input,   want.peak_in);
          check_field("out_peak_left",    out_peak_left,    want.peak_l);
          check_field("out_peak_right",   out_peak_right,   want.peak_r);
          check_field("out_lfo_display",  out_lfo_display,  want.disp);
        end
      end
      if (in_valid && !in_stall)
        expected_frames.push_back(next_frame(in_sample_in, in_last_of_block));
    end
    outstanding = expected_frames.size();
  end

endmodule

// ===== test/stereo_tremolo_with_peak_meter_tb.sv =====
// ----------------------------------------------------------------------------
// stereo_tremolo_with_peak_meter_tb: top level of the tremolo / meter bench
// Drives mono samples in blocks under a series of register settings, with
// random gaps on the input and random stalls on the result side, and lets
// the checker predict and compare every stereo frame. Gives the verdict.
// ----------------------------------------------------------------------------
module stereo_tremolo_with_peak_meter_tb import stpm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Word slot just past the register map; writes there must be dropped
  localparam int REG_UNMAPPED = 3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEGMENTS     = 6;
  localparam int SEGMENT_ITEMS = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [23:0] in_sample_in = '0;
  logic               in_last_of_block = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] out_left;
  logic signed [23:0] out_right;
  logic               out_meters_valid;
  logic        [22:0] out_peak_input;
  logic        [22:0] out_peak_left;
  logic        [22:0] out_peak_right;
  logic signed [15:0] out_lfo_display;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic        [3:0]  paddr = '0;
  logic        [31:0] pwdata = '0;
  logic        [31:0] prdata;
  logic               pready;

  int mismatches;
  int outstanding;

  // calm: no idling on either side; hold_request: one long receiver hold-off
  logic calm = 1'b0;
  logic hold_request = 1'b0;
  logic hold_served = 1'b0;
  int   hold_left = 0;

  always #4 clk = ~clk;

  stereo_tremolo_with_peak_meter u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_last_of_block (in_last_of_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left         (out_left),
    .out_right        (out_right),
    .out_meters_valid (out_meters_valid),
    .out_peak_input   (out_peak_input),
    .out_peak_left    (out_peak_left),
    .out_peak_right   (out_peak_right),
    .out_lfo_display  (out_lfo_display),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  tremolo_meter_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_last_of_block (in_last_of_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_left         (out_left),
    .out_right        (out_right),
    .out_meters_valid (out_meters_valid),
    .out_peak_input   (out_peak_input),
    .out_peak_left    (out_peak_left),
    .out_peak_right   (out_peak_right),
    .out_lfo_display  (out_lfo_display),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  // Result side: random stalls, except while calm. Once hold_request is
  // raised, stall until the HOLD_CYCLES countdown runs out so the block backs
  // up and stalls its input while the sender keeps offering samples.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 22);
    end
  end

  // Abort on a hang
  initial begin : watchdog
    for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("stereo_tremolo_with_peak_meter_tb: done, errors");
    $finish;
  end

  // Mostly full-scale random, with extremes, silence and small values mixed in
  function automatic logic signed [23:0] pick_sample();
    case ($urandom_range(9))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return 24'($signed($urandom_range(512)) - 256);
      3:       return '0;
      default: return 24'($urandom());
    endcase
  endfunction

  // Offer one sample transaction; hold it until accepted. Drop valid only
  // when an idle gap is taken, so valid is never lowered and raised in one step.
  task automatic send_sample(input logic signed [23:0] smp, input logic last_flag);
    int gap;
    if (!calm && $urandom_range(99) < 22) begin
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_in     <= smp;
    in_last_of_block <= last_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the transfer completes when pready is high
  task automatic apb_access(input bit write_op, input int slot, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_op;
    paddr   <= 4'(slot * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait until every predicted frame has come back; step
  // the clock first so the checker has counted the last accepted transaction
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (settle) @(posedge clk);
  endtask

  // Write all three registers (block idle), optionally poke the unmapped
  // slot, then read everything back for the checker to compare
  task automatic program_tremolo(input logic [31:0] gain, input logic [31:0] step,
                                 input logic [31:0] depth, input bit poke_unmapped);
    drain(4);
    apb_access(1'b1, REG_GAIN_LINEAR, gain);
    apb_access(1'b1, REG_PHASE_STEP, step);
    apb_access(1'b1, REG_LFO_DEPTH, depth);
    if (poke_unmapped) apb_access(1'b1, REG_UNMAPPED, $urandom());
    apb_access(1'b0, REG_GAIN_LINEAR, '0);
    apb_access(1'b0, REG_PHASE_STEP, '0);
    apb_access(1'b0, REG_LFO_DEPTH, '0);
  endtask

  initial begin : stimulus
    logic [31:0] gain, step, depth;
    int          sent, block_len;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings (unity gain, no modulation): full-scale extremes, the
    // most negative sample saturating in the input peak, an all-zero block
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b1);
    send_sample(24'sh000000, 1'b1);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd1, 1'b1);

    // Largest gain saturates the full-scale samples; depth above full must clamp;
    // garbage in the upper bits and a write to the unmapped slot are dropped
    program_tremolo(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd4096, 1'b0);
    send_sample(-24'sd4096, 1'b1);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);

    // Zero gain silences the output at full depth
    program_tremolo(32'd0, 32'h4000_0000, 32'd65536, 1'b0);
    send_sample(24'sh7FFFFF, 1'b1);
    send_sample(-24'sd5, 1'b1);

    // Quarter-turn steps walk all four quadrants, each at the same table
    // index, since the step leaves the index bits unchanged
    program_tremolo(32'd65536, 32'h4000_0000, 32'd65536, 1'b0);
    repeat (4) send_sample(24'sh400000, 1'b1);

    // Half gain, half depth, an odd step that lands mid-table
    program_tremolo(32'h0000_8000, 32'h0FF0_1234, 32'd32768, 1'b0);
    for (int i = 0; i < 6; i++) send_sample(pick_sample(), i == 5);

    // Random part: per segment a fresh setting, then blocks of random length
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(4))
        0:       gain = 32'd0;
        1:       gain = 32'd65536;
        2:       gain = 32'hFFFFF;
        3:       gain = $urandom_range(1, 131072);
        default: gain = $urandom();
      endcase
      case ($urandom_range(4))
        0:       step = 32'd0;
        1:       step = 32'h7FFF_FFFF;
        2:       step = $urandom_range(1, 1 << 24);
        3:       step = 32'h4000_0000;
        default: step = $urandom();
      endcase
      case ($urandom_range(4))
        0:       depth = 32'd0;
        1:       depth = 32'd65536;
        2:       depth = 32'h1FFFF;
        3:       depth = $urandom_range(0, 65536);
        default: depth = $urandom();
      endcase
      // Keep segment 1 at a modest gain so the meters see unsaturated values
      if (seg == 1) gain = $urandom_range(16384, 65536);
      program_tremolo(gain, step, depth, $urandom_range(1) == 1);

      // Segment 2 runs with no idling; segment 4 carries the long hold-off
      calm         <= (seg == 2);
      hold_request <= (seg == 4);

      sent = 0;
      while (sent < SEGMENT_ITEMS) begin
        block_len = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        for (int i = 0; i < block_len; i++) send_sample(pick_sample(), i == block_len - 1);
        sent += block_len;
      end
    end

    // Drain, let the sequencer settle, then give the verdict
    calm <= 1'b0;
    drain(40);
    if (mismatches == 0) begin
      $display("stereo_tremolo_with_peak_meter_tb: done, clean");
    end else begin
      $display("stereo_tremolo_with_peak_meter_tb: done, errors");
    end
    $finish;
  end

endmodule
